// ----- src/vne_pkg.sv -----
// Package for the vector norm engine: field widths, step counts and the
// command/status structs between controller and datapath. No dependencies.
package vne_pkg;

	localparam int ELEM_W     = 16;          // Q8.8 element
	localparam int MAG_W      = 17;          // |element|, 0..32768
	localparam int SQ_W       = 2 * MAG_W;   // product width
	localparam int SUM_W      = 26;          // abs sum / sum_norm
	localparam int SSQ_W      = 41;          // sum of squares
	localparam int ROOT_W     = 21;          // euclid_norm
	localparam int MAXN_W     = 16;          // max_norm
	localparam int RAD_W      = 2 * ROOT_W;  // radicand padded to even width
	localparam int REM_W      = ROOT_W + 2;  // partial remainder
	localparam int ROOT_STEPS = ROOT_W;      // one root bit per step
	localparam int CNT_W      = $clog2(ROOT_STEPS + 1);
	localparam int OUT_W      = 64;          // m_tdata width, byte aligned

	typedef struct packed {
		logic acc_en;      // element beat accepted
		logic root_start;  // accepted beat is the last one
		logic root_step;   // advance square root by one bit
		logic out_load;    // move results into the output register
	} vne_cmd_t;

	typedef struct packed {
		logic root_done;   // all root bits resolved
	} vne_stat_t;

endpackage

// ----- src/vector_norm_engine.sv -----
// Vector norm engine: after the last element beat the square root resolves its
// 21 bits one per step, then the results are loaded into the output register.
// Elements are taken one beat per cycle while s_tready is high; after the last
// beat s_tready drops while the root runs and until the output register is free;
// an unaccepted result beat stretches that gap until it is taken.
// arst_n clears the accumulators, the FSM and m_tvalid asynchronously.
module vector_norm_engine (
	input  logic        clk,
	input  logic        arst_n,
	// element stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] element (signed Q8.8)
	input  logic        s_tlast,   // last element of the vector
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [25:0] sum_norm, [46:26] euclid_norm,
	                               // [62:47] max_norm, [63] zero
);

	vne_pkg::vne_cmd_t  cmd;
	vne_pkg::vne_stat_t stat;

	// FSM: accumulate, run root steps, then load the output register, holding until it frees
	vne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// saturating sums, running peak, one-bit-per-cycle square root
	vne_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.element (s_tdata),
		.cmd     (cmd),
		.stat    (stat),
		.m_tdata (m_tdata)
	);

endmodule

// ----- src/vne_ctrl.sv -----
// Controller for the vector norm engine: handshake and sequencing FSM.
// Depends on vne_pkg.
module vne_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  vne_pkg::vne_stat_t stat,
	output vne_pkg::vne_cmd_t  cmd
);

	localparam logic [1:0] ST_ACCUM = 2'd0;
	localparam logic [1:0] ST_ROOT  = 2'd1;
	localparam logic [1:0] ST_HOLD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_ACCUM);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d        = state_q;
		cmd.acc_en     = 1'b0;
		cmd.root_start = 1'b0;
		cmd.root_step  = 1'b0;
		cmd.out_load   = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				cmd.acc_en     = s_tvalid;
				cmd.root_start = s_tvalid && s_tlast;
				if (s_tvalid && s_tlast) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (!stat.root_done) begin
					cmd.root_step = 1'b1;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACCUM;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/vne_datapath.sv -----
// Datapath for the vector norm engine: accumulators, bit-serial square root
// and output register. Depends on vne_pkg.
module vne_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [vne_pkg::ELEM_W-1:0]       element,
	input  vne_pkg::vne_cmd_t                cmd,
	output vne_pkg::vne_stat_t               stat,
	output logic [vne_pkg::OUT_W-1:0]        m_tdata
);

	logic [vne_pkg::SUM_W-1:0]  abs_sum_q;
	logic [vne_pkg::SSQ_W-1:0]  square_sum_q;
	logic [vne_pkg::MAG_W-1:0]  abs_peak_q;

	logic [vne_pkg::SUM_W-1:0]  res_sum_q;
	logic [vne_pkg::MAXN_W-1:0] res_peak_q;
	logic [vne_pkg::RAD_W-1:0]  rad_q;
	logic [vne_pkg::REM_W-1:0]  rem_q;
	logic [vne_pkg::ROOT_W-1:0] root_q;
	logic [vne_pkg::CNT_W-1:0]  cnt_q;
	logic [vne_pkg::OUT_W-1:0]  out_q;

	logic [vne_pkg::MAG_W-1:0]  mag;
	logic [vne_pkg::SQ_W-1:0]   sq;
	logic [vne_pkg::SUM_W:0]    sum_wide;
	logic [vne_pkg::SSQ_W:0]    ssq_wide;
	logic [vne_pkg::SUM_W-1:0]  sum_sat;
	logic [vne_pkg::SSQ_W-1:0]  ssq_sat;
	logic [vne_pkg::MAG_W-1:0]  peak_next;
	logic [vne_pkg::REM_W-1:0]  rem_shift;
	logic [vne_pkg::REM_W-1:0]  trial;

	// two's complement magnitude; -32768 maps to 32768
	always_comb begin
		if (element[vne_pkg::ELEM_W-1]) begin
			mag = ~{1'b1, element} + vne_pkg::MAG_W'(1);
		end else begin
			mag = {1'b0, element};
		end
		sq        = mag * mag;
		sum_wide  = {1'b0, abs_sum_q} + (vne_pkg::SUM_W+1)'(mag);
		ssq_wide  = {1'b0, square_sum_q} + (vne_pkg::SSQ_W+1)'(sq);
		sum_sat   = sum_wide[vne_pkg::SUM_W] ? '1 : sum_wide[vne_pkg::SUM_W-1:0];
		ssq_sat   = ssq_wide[vne_pkg::SSQ_W] ? '1 : ssq_wide[vne_pkg::SSQ_W-1:0];
		peak_next = (mag > abs_peak_q) ? mag : abs_peak_q;
	end

	// restoring root: bring down two radicand bits, try root*4+1
	assign rem_shift = {rem_q[vne_pkg::REM_W-3:0], rad_q[vne_pkg::RAD_W-1 -: 2]};
	assign trial     = {root_q, 2'b01};

	assign stat.root_done = (cnt_q == vne_pkg::CNT_W'(vne_pkg::ROOT_STEPS));
	assign m_tdata        = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_sum_q    <= '0;
			square_sum_q <= '0;
			abs_peak_q   <= '0;
			cnt_q        <= '0;
		end else if (cmd.acc_en) begin
			if (cmd.root_start) begin
				abs_sum_q    <= '0;
				square_sum_q <= '0;
				abs_peak_q   <= '0;
				cnt_q        <= '0;
			end else begin
				abs_sum_q    <= sum_sat;
				square_sum_q <= ssq_sat;
				abs_peak_q   <= peak_next;
			end
		end else if (cmd.root_step) begin
			cnt_q <= cnt_q + vne_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			res_sum_q  <= sum_sat;
			res_peak_q <= peak_next[vne_pkg::MAXN_W-1:0];
			rad_q      <= {1'b0, ssq_sat};
			rem_q      <= '0;
			root_q     <= '0;
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[vne_pkg::RAD_W-3:0], 2'b00};
			if (rem_shift >= trial) begin
				rem_q  <= rem_shift - trial;
				root_q <= {root_q[vne_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				root_q <= {root_q[vne_pkg::ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_q <= vne_pkg::OUT_W'({res_peak_q, root_q, res_sum_q});
		end
	end

endmodule

// ----- src/vne_checker.sv -----
// Port-level checker for the vector norm engine, bound to the top level.
// Depends only on the top level's ports.
module vne_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// input closes while the root runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input accepted during root");

	// peak never exceeds the sum
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[62:47] <= m_tdata[25:0]))
		else $error("max_norm above sum_norm");

	// euclidean norm never exceeds the sum norm; pad bit stays clear
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[46:26] <= m_tdata[25:0]) && !m_tdata[63])
		else $error("euclid_norm above sum_norm or pad bit set");

endmodule

bind vector_norm_engine vne_checker u_vne_checker (.*);

// ----- sim/tb_vector_norm_engine.sv -----
// Self-checking bench for vector_norm_engine: streams Q8.8 vectors into the
// element port and checks every result beat against a local norm predictor or a typed result.
// Depends on vne_pkg (field widths) and the vector_norm_engine RTL.
module tb_vector_norm_engine;

	// one result beat, laid out like m_tdata[62:0] (sum_norm in the low bits)
	typedef struct packed {
		logic [vne_pkg::MAXN_W-1:0] maxn;
		logic [vne_pkg::ROOT_W-1:0] euclid;
		logic [vne_pkg::SUM_W-1:0]  sum;
	} norms_t;

	// directed row: element beat, plus the result where it is obvious by hand
	typedef struct packed {
		logic [vne_pkg::ELEM_W-1:0] elem;
		logic                       last;
		logic                       given;   // 1: use the typed result below
		norms_t                     norms;
	} elem_row_t;

	localparam longint unsigned ABS_FULL = (64'd1 << vne_pkg::SUM_W) - 1;
	localparam longint unsigned SSQ_FULL = (64'd1 << vne_pkg::SSQ_W) - 1;
	localparam int IDLE_PCT  = 23;     // chance of an idle cycle on either side
	localparam int HOLD_LEN  = 400;    // long receiver hold-off, in cycles
	localparam int RAND_BEATS = 900;   // random element beats
	localparam int FULL_LEN  = 130;    // long full-scale vector
	localparam int DRAIN_CYC = 40;     // longer than the root latency

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;   // [15:0] element (signed Q8.8)
	logic              s_tlast = 1'b0; // last element of the vector
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [63:0]       m_tdata;        // [25:0] sum_norm, [46:26] euclid_norm,
	                                   // [62:47] max_norm, [63] zero

	// predictor state, same widths as the block's accumulators
	logic [vne_pkg::SUM_W-1:0] abs_acc = '0;
	logic [vne_pkg::SSQ_W-1:0] sq_acc = '0;
	logic [vne_pkg::MAG_W-1:0] peak = '0;

	norms_t norm_q[$];          // results owed by the block, oldest first
	int unsigned err_count = 0;
	bit quiet = 1'b0;           // both sides: no idle cycles while set
	bit hold_req = 1'b0;        // sender asks the sink for a long hold-off

	// directed vectors; rows without a typed result go to the predictor
	elem_row_t elem_tab [19] = '{
		{16'h0000, 1'b1, 1'b1, 16'd0,     21'd0,     26'd0},     // zero vector
		{16'h8000, 1'b1, 1'b1, 16'd32768, 21'd32768, 26'd32768}, // most negative
		{16'h7FFF, 1'b1, 1'b1, 16'd32767, 21'd32767, 26'd32767}, // most positive
		{16'h0100, 1'b1, 1'b1, 16'd256,   21'd256,   26'd256},   // 1.0
		{16'hFFFF, 1'b1, 1'b1, 16'd1,     21'd1,     26'd1},     // -1 lsb
		{16'h0300, 1'b0, 1'b0, 63'd0},                           // 3.0
		{16'hFC00, 1'b1, 1'b1, 16'd1024,  21'd1280,  26'd1792},  // -4.0: 3-4-5
		{16'h0001, 1'b0, 1'b0, 63'd0},
		{16'h0002, 1'b0, 1'b0, 63'd0},
		{16'hFFFD, 1'b1, 1'b1, 16'd3,     21'd3,     26'd6},     // sqrt(14) floors to 3
		{16'h8000, 1'b0, 1'b0, 63'd0},                           // alternating extremes
		{16'h7FFF, 1'b0, 1'b0, 63'd0},
		{16'h8000, 1'b0, 1'b0, 63'd0},
		{16'h7FFF, 1'b1, 1'b0, 63'd0},
		{16'h5555, 1'b0, 1'b0, 63'd0},                           // checkerboard bits
		{16'hAAAA, 1'b1, 1'b0, 63'd0},
		{16'h7FFF, 1'b0, 1'b0, 63'd0},
		{16'h8001, 1'b0, 1'b0, 63'd0},
		{16'h0000, 1'b1, 1'b0, 63'd0}                            // trailing zero element
	};

	vector_norm_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// hard stop in case the block wedges
	initial begin
		#2_000_000;
		$display("tb_vector_norm_engine: errors");
		$finish;
	end

	function automatic void flag_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	// floor square root, one result bit per pass from the top pair down
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << (2 * (vne_pkg::ROOT_W - 1));
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// fold one element into the running norms; on the last element hand back
	// the three norms and start the next vector from zero
	function automatic bit norm_step(input logic [vne_pkg::ELEM_W-1:0] e, input logic l,
		output norms_t r);
		logic [vne_pkg::MAG_W-1:0] mag;
		longint unsigned s, q;
		mag = e[vne_pkg::ELEM_W-1] ? 17'h10000 - {1'b0, e} : {1'b0, e};
		// both sums saturate rather than wrap on over-long vectors
		s = longint'(abs_acc) + mag;
		if (s > ABS_FULL)
			s = ABS_FULL;
		q = longint'(sq_acc) + longint'(mag) * longint'(mag);
		if (q > SSQ_FULL)
			q = SSQ_FULL;
		abs_acc = s[vne_pkg::SUM_W-1:0];
		sq_acc = q[vne_pkg::SSQ_W-1:0];
		if (mag > peak)
			peak = mag;
		r = '0;
		if (!l)
			return 1'b0;
		r.sum = abs_acc;
		r.euclid = vne_pkg::ROOT_W'(floor_root(sq_acc));
		r.maxn = peak[vne_pkg::MAXN_W-1:0];
		abs_acc = '0;
		sq_acc = '0;
		peak = '0;
		return 1'b1;
	endfunction

	// offer one element beat, idling at random first; returns at the accepting edge
	task automatic send_elem(input logic [vne_pkg::ELEM_W-1:0] e, input logic l,
		input bit given, input norms_t typed);
		norms_t pred;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= e;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		if (norm_step(e, l, pred))
			norm_q.push_back(given ? typed : pred);
	endtask

	// element source: directed table, full-scale vector, then random vectors
	initial begin : elem_source
		int unsigned sent, len, r;
		logic [vne_pkg::ELEM_W-1:0] e;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (elem_tab[i])
			send_elem(elem_tab[i].elem, elem_tab[i].last, elem_tab[i].given,
				elem_tab[i].norms);

		// long run of -32768: large sums and a large root
		for (int k = 0; k < FULL_LEN; k++)
			send_elem(16'h8000, k == FULL_LEN - 1, 1'b0, '0);

		sent = 0;
		while (sent < RAND_BEATS) begin
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(8, 1);
			else if (r < 95)
				len = $urandom_range(40, 9);
			else
				len = $urandom_range(120, 41);
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(99);
				if (r < 15) begin
					case ($urandom_range(3))
						0: e = 16'h8000;
						1: e = 16'h7FFF;
						2: e = 16'h0000;
						default: e = 16'hFFFF;
					endcase
				end else if (r < 40) begin
					e = 16'(int'($urandom_range(1024)) - 512);
				end else begin
					e = 16'($urandom);
				end
				send_elem(e, k == len - 1, 1'b0, '0);
				sent++;
				// sink stalls for a long stretch while elements keep coming
				if (sent == 300)
					hold_req = 1'b1;
				quiet = (sent >= 600 && sent < 800);
			end
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		while (norm_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (err_count == 0)
			$display("tb_vector_norm_engine: clean");
		else
			$display("tb_vector_norm_engine: errors");
		$finish;
	end

	// result sink: checks each accepted beat, drives m_tready for the next cycle
	initial begin : result_sink
		int unsigned hold_left;
		norms_t got, want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata[62:0];
				if (norm_q.size() == 0) begin
					flag_error($sformatf("unexpected result sum=%0d euclid=%0d max=%0d",
						got.sum, got.euclid, got.maxn));
				end else begin
					want = norm_q.pop_front();
					if (got.sum !== want.sum || got.euclid !== want.euclid
						|| got.maxn !== want.maxn)
						flag_error($sformatf(
							"norm mismatch: exp sum=%0d euclid=%0d max=%0d, got %0d %0d %0d",
							want.sum, want.euclid, want.maxn,
							got.sum, got.euclid, got.maxn));
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

endmodule

// ----- files.f -----
src/vne_pkg.sv
src/vne_ctrl.sv
src/vne_datapath.sv
src/vector_norm_engine.sv
src/vne_checker.sv
sim/tb_vector_norm_engine.sv
